FILE: sv/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg
// Types, constants and helpers shared by the ASCII count frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

    localparam int COUNT_W     = 32;
    localparam int NUM_FIELDS  = 4;
    localparam int FIELD_IDX_W = 3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [3:0] HEX_TEN   = 4'd10;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } frame_in_t;

    typedef struct packed {
        logic                      frame_valid;
        logic signed [COUNT_W-1:0] static_pressure_count;
        logic signed [COUNT_W-1:0] dynamic_pressure_count;
        logic signed [COUNT_W-1:0] alpha_count;
        logic signed [COUNT_W-1:0] beta_count;
    } frame_out_t;

    typedef logic [NUM_FIELDS-1:0][COUNT_W-1:0] count_set_t;

    // control from the frame tracker to the field parser
    typedef struct packed {
        logic       step;    // a request was accepted this cycle
        logic       parse;   // the byte leaving the delay line is a field byte
        logic       last;    // the accepted request ends the frame
        logic [7:0] pbyte;   // byte leaving the delay line
    } field_ctrl_t;

    // end-of-frame view of the field parser
    typedef struct packed {
        logic done;          // all four fields collected
        logic malformed;     // an empty field was seen
    } field_status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t h;
        h.ok     = 1'b1;
        h.nibble = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            h.nibble = 4'(c - CH_ZERO);
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            h.nibble = 4'(c - CH_UP_A) + HEX_TEN;
        end
        else if (c >= CH_LO_A && c <= CH_LO_F)
        begin
            h.nibble = 4'(c - CH_LO_A) + HEX_TEN;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: sv/ascii_count_frame_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_count_frame_parser_core
// ASCII frame parser: '$' header, four signed decimal count fields and an
// additive hex checksum tail.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one frame byte per request, with
//   frame_end set on the final byte. One byte is taken in every cycle with
//   in_valid high, unless a final byte meets a held result and low out_ready.
//   On the request that carries frame_end the block loads one result into
//   its output register; out_valid rises in the next cycle, and out_data
//   holds the valid flag and the four counts (zero when the frame is
//   rejected). Non-final bytes are still taken while a result waits on a
//   stalled out_ready; only a final byte waits until the output register
//   frees.
//   cfg_we/cfg_wdata write the checksum enable (reset 1); write it only
//   while no frame is in flight.
//   Reset clears all frame state and the output register.
// ----------------------------------------------------------------------------
module ascii_count_frame_parser_core #(
    parameter int FIELD_START_POS = 21,
    parameter int VALUE_WIDTH     = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  acfp_pkg::frame_in_t    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output acfp_pkg::frame_out_t   out_data,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata
);

    localparam int POS_W = $clog2(FIELD_START_POS + 2);
    localparam logic [POS_W-1:0] POS_START = POS_W'(FIELD_START_POS);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(FIELD_START_POS + 1);

    logic [2:0][7:0]          tail_reg;
    logic [1:0]               held_reg, held_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     start_ok_reg, start_ok_next;
    logic [7:0]               sum_reg, sum_next;
    logic                     chk_reg;
    logic                     out_valid_reg;
    acfp_pkg::frame_out_t     out_data_reg, result;

    logic                     step;
    logic                     parse;
    acfp_pkg::field_ctrl_t    fctrl;
    acfp_pkg::field_status_t  fstat;
    acfp_pkg::count_set_t     counts;
    acfp_pkg::hex_digit_t     hex_hi, hex_lo;
    logic                     frame_ok;
    logic                     sum_ok;

    assign in_ready = !out_valid_reg || out_ready || !in_data.frame_end;
    assign step     = in_valid && in_ready;
    assign parse    = held_reg == 2'd3;

    assign fctrl.step  = step;
    assign fctrl.parse = step && parse && pos_reg >= POS_START;
    assign fctrl.last  = step && in_data.frame_end;
    assign fctrl.pbyte = tail_reg[0];

    acfp_fields #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_fields (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fctrl),
        .status (fstat),
        .counts (counts)
    );

    always_comb
    begin
        held_next     = (held_reg == 2'd3) ? held_reg : held_reg + 1'b1;
        pos_next      = pos_reg;
        start_ok_next = start_ok_reg;
        sum_next      = sum_reg;
        if (parse)
        begin
            if (pos_reg == '0)
                start_ok_next = tail_reg[0] == acfp_pkg::CH_DOLLAR;
            sum_next = sum_reg + tail_reg[0];
            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 1'b1;
        end
    end

    // checksum digits after the shift: the old newest byte and the new byte
    assign hex_hi = acfp_pkg::hex_decode(tail_reg[2]);
    assign hex_lo = acfp_pkg::hex_decode(in_data.frame_byte);
    assign sum_ok = hex_hi.ok && hex_lo.ok && {hex_hi.nibble, hex_lo.nibble} == sum_next;

    assign frame_ok = held_next == 2'd3 && pos_next > POS_START && start_ok_next
                      && !fstat.malformed && fstat.done && (sum_ok || !chk_reg);

    always_comb
    begin
        result.frame_valid            = frame_ok;
        result.static_pressure_count  = frame_ok ? counts[0] : '0;
        result.dynamic_pressure_count = frame_ok ? counts[1] : '0;
        result.alpha_count            = frame_ok ? counts[2] : '0;
        result.beta_count             = frame_ok ? counts[3] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= '0;
            held_reg     <= '0;
            pos_reg      <= '0;
            start_ok_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else if (step)
        begin
            if (in_data.frame_end)
            begin
                tail_reg     <= '0;
                held_reg     <= '0;
                pos_reg      <= '0;
                start_ok_reg <= 1'b0;
                sum_reg      <= '0;
            end
            else
            begin
                tail_reg     <= {in_data.frame_byte, tail_reg[2], tail_reg[1]};
                held_reg     <= held_next;
                pos_reg      <= pos_next;
                start_ok_reg <= start_ok_next;
                sum_reg      <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chk_reg <= 1'b1;
        else if (cfg_we)
            chk_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && in_data.frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_data_reg <= '0;
        else if (step && in_data.frame_end)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result appears only after a final byte was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.frame_end))
        else $error("result without final byte");

    // rejected frames carry zero counts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_valid |->
            out_data.static_pressure_count == '0 && out_data.dynamic_pressure_count == '0
            && out_data.alpha_count == '0 && out_data.beta_count == '0)
        else $error("nonzero counts on rejected frame");

    // nothing is parsed before the delay line is full
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd3 |-> pos_reg == '0 && sum_reg == '0)
        else $error("parsed byte before delay line filled");

    // a final byte clears the frame tracker
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.frame_end |=> held_reg == 2'd0 && pos_reg == '0)
        else $error("frame state not cleared at frame end");

endmodule

FILE: sv/acfp_fields.sv
// ----------------------------------------------------------------------------
// acfp_fields
// Comma-separated signed decimal field parser; collects four saturating counts.
// ----------------------------------------------------------------------------
module acfp_fields #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  acfp_pkg::field_ctrl_t     ctrl,
    output acfp_pkg::field_status_t   status,
    output acfp_pkg::count_set_t      counts
);

    localparam int ACC_W  = VALUE_WIDTH - 1;
    localparam int PROD_W = ACC_W + 4;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_STOPPED
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic                                  nonempty_reg, nonempty_next;
    logic                                  negative_reg, negative_next;
    logic [ACC_W-1:0]                      acc_reg, acc_next;
    logic [acfp_pkg::FIELD_IDX_W-1:0]      idx_reg, idx_next;
    acfp_pkg::count_set_t                  vals_reg, vals_next;
    logic                                  malformed_reg, malformed_next;

    logic [PROD_W-1:0]                     prod;
    logic [3:0]                            digit_val;
    logic                                  is_digit;
    logic                                  take;
    logic                                  finish;
    logic [acfp_pkg::COUNT_W-1:0]          mag;
    logic [acfp_pkg::COUNT_W-1:0]          signed_val;
    logic [acfp_pkg::FIELD_IDX_W-1:0]      idx_fin;
    acfp_pkg::count_set_t                  vals_fin;

    assign is_digit  = ctrl.pbyte >= acfp_pkg::CH_ZERO && ctrl.pbyte <= acfp_pkg::CH_NINE;
    assign digit_val = 4'(ctrl.pbyte - acfp_pkg::CH_ZERO);
    // acc * 10 + digit as two shifts and adds
    assign prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + PROD_W'(digit_val);

    always_comb
    begin
        phase_next     = phase_reg;
        nonempty_next  = nonempty_reg;
        negative_next  = negative_reg;
        acc_next       = acc_reg;
        malformed_next = malformed_reg;
        finish         = 1'b0;
        take           = 1'b0;

        if (ctrl.parse && !idx_reg[2] && !malformed_reg)
        begin
            if (ctrl.pbyte == acfp_pkg::CH_COMMA)
            begin
                if (!nonempty_reg)
                    malformed_next = 1'b1;
                else
                    finish = 1'b1;
            end
            else
            begin
                nonempty_next = 1'b1;
                if (phase_reg == PH_LEAD)
                begin
                    priority if (ctrl.pbyte == acfp_pkg::CH_SPACE
                                 || ctrl.pbyte == acfp_pkg::CH_TAB)
                    begin
                        take = 1'b0;
                    end
                    else if (ctrl.pbyte == acfp_pkg::CH_MINUS)
                    begin
                        negative_next = 1'b1;
                        phase_next    = PH_DIGITS;
                    end
                    else if (ctrl.pbyte == acfp_pkg::CH_PLUS)
                    begin
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                        take       = 1'b1;
                    end
                end
                else if (phase_reg == PH_DIGITS)
                begin
                    take = 1'b1;
                end

                if (take)
                begin
                    if (is_digit)
                    begin
                        if (prod[PROD_W-1:ACC_W] != '0)
                            acc_next = '1;
                        else
                            acc_next = prod[ACC_W-1:0];
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
            end
        end

        // an open field at the end of the frame closes as if by a comma
        if (ctrl.last && !malformed_next && !idx_reg[2] && nonempty_next)
            finish = 1'b1;
    end

    assign mag        = acfp_pkg::COUNT_W'(acc_next);
    assign signed_val = negative_next ? (acfp_pkg::COUNT_W'(0) - mag) : mag;

    always_comb
    begin
        vals_fin = vals_reg;
        idx_fin  = idx_reg;
        if (finish)
        begin
            vals_fin[idx_reg[1:0]] = signed_val;
            idx_fin                = idx_reg + 1'b1;
        end
    end

    assign idx_next  = idx_fin;
    assign vals_next = vals_fin;

    assign status.done      = idx_fin[2];
    assign status.malformed = malformed_next;
    assign counts           = vals_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            nonempty_reg  <= 1'b0;
            negative_reg  <= 1'b0;
            acc_reg       <= '0;
            idx_reg       <= '0;
            vals_reg      <= '0;
            malformed_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.last)
            begin
                phase_reg     <= PH_LEAD;
                nonempty_reg  <= 1'b0;
                negative_reg  <= 1'b0;
                acc_reg       <= '0;
                idx_reg       <= '0;
                vals_reg      <= '0;
                malformed_reg <= 1'b0;
            end
            else
            begin
                idx_reg       <= idx_next;
                vals_reg      <= vals_next;
                malformed_reg <= malformed_next;
                if (finish)
                begin
                    phase_reg    <= PH_LEAD;
                    nonempty_reg <= 1'b0;
                    negative_reg <= 1'b0;
                    acc_reg      <= '0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    nonempty_reg <= nonempty_next;
                    negative_reg <= negative_next;
                    acc_reg      <= acc_next;
                end
            end
        end
    end

    // field counter never runs past four
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg[2] |-> idx_reg[1:0] == 2'b00)
        else $error("field index beyond four");

    // the accumulator only moves while digits are being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEAD |-> acc_reg == '0)
        else $error("accumulator nonzero before digits");

    // parsing stops for good once the frame is malformed
    assert property (@(posedge clk) disable iff (!rst_n)
        malformed_reg && ctrl.step && !ctrl.last |=> malformed_reg && $stable(idx_reg))
        else $error("field state moved after malformed frame");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ascii_count_frame_parser_core. Frames are sent one
// byte per request, a table of hand-written frames first, then random ones,
// mostly well formed with random fields and a few noise or damaged frames.
// A behavioral parser copy or a typed table row predicts each frame result,
// and every output request is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int         FIELD_START   = 21;
    localparam int         ITEM_GOAL     = 1750;
    localparam int         SINK_HOLD_CYC = 400;
    localparam int         QUIET_LIMIT   = 5000;
    localparam int         SETTLE_CYC    = 3;
    localparam int         NUM_ROWS      = 16;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [63:0] MAG_MAX      = 64'h0000_0000_7FFF_FFFF;

    typedef enum logic [1:0] {FLD_LEAD, FLD_DIGITS, FLD_STOPPED} fld_state_t;
    typedef enum {TAIL_UPPER, TAIL_LOWER, TAIL_WRONG, TAIL_TEXT} tail_kind_t;

    typedef struct {
        string                body;
        tail_kind_t           tail;
        string                tail_txt;
        bit                   chk;
        bit                   typed;
        acfp_pkg::frame_out_t want;
    } frame_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    acfp_pkg::frame_in_t  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    acfp_pkg::frame_out_t out_data;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;

    ascii_count_frame_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame parser prediction
    // ------------------------------------------------------------------
    logic [7:0]  tail_hold [3];
    int          tail_cnt;
    int          parsed_pos;
    bit          lead_ok;
    logic [7:0]  run_sum;
    int          fld_num;
    fld_state_t  fld_state;
    bit          fld_seen;
    bit          fld_minus;
    logic [63:0] fld_mag;
    logic [31:0] fld_vals [4];
    bit          frame_bad;
    bit          chk_on = 1'b1;

    acfp_pkg::frame_out_t frame_results_q [$];
    bit                   use_typed = 1'b0;
    acfp_pkg::frame_out_t typed_want;

    task automatic clear_field_state();
        fld_state = FLD_LEAD;
        fld_seen  = 1'b0;
        fld_minus = 1'b0;
        fld_mag   = '0;
    endtask

    task automatic clear_frame_state();
        for (int i = 0; i < 3; i++)
        begin
            tail_hold[i] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            fld_vals[i] = '0;
        end
        tail_cnt   = 0;
        parsed_pos = 0;
        lead_ok    = 1'b0;
        run_sum    = '0;
        fld_num    = 0;
        frame_bad  = 1'b0;
        clear_field_state();
    endtask

    task automatic close_field();
        logic [31:0] v;
        v = fld_mag[31:0];
        if (fld_minus)
        begin
            v = 32'd0 - v;
        end
        if (fld_num < 4)
        begin
            fld_vals[fld_num] = v;
        end
        fld_num++;
        clear_field_state();
    endtask

    task automatic field_char(input logic [7:0] b);
        bit digit;
        digit = (b >= acfp_pkg::CH_ZERO && b <= acfp_pkg::CH_NINE);
        if (b == acfp_pkg::CH_COMMA)
        begin
            // a comma with nothing before it is an empty field
            if (!fld_seen)
            begin
                frame_bad = 1'b1;
            end
            else
            begin
                close_field();
            end
            return;
        end
        fld_seen = 1'b1;
        if (fld_state == FLD_LEAD)
        begin
            if (b == acfp_pkg::CH_SPACE || b == acfp_pkg::CH_TAB)
            begin
                return;
            end
            if (b == acfp_pkg::CH_MINUS)
            begin
                fld_minus = 1'b1;
                fld_state = FLD_DIGITS;
                return;
            end
            if (b == acfp_pkg::CH_PLUS)
            begin
                fld_state = FLD_DIGITS;
                return;
            end
            fld_state = FLD_DIGITS;
        end
        if (fld_state == FLD_DIGITS)
        begin
            if (digit)
            begin
                fld_mag = fld_mag * 64'd10 + {56'd0, b - acfp_pkg::CH_ZERO};
                if (fld_mag > MAG_MAX)
                begin
                    fld_mag = MAG_MAX;
                end
            end
            else
            begin
                fld_state = FLD_STOPPED;
            end
        end
    endtask

    task automatic parsed_char(input logic [7:0] b);
        if (parsed_pos == 0)
        begin
            lead_ok = (b == acfp_pkg::CH_DOLLAR);
        end
        if (parsed_pos >= FIELD_START && fld_num < 4 && !frame_bad)
        begin
            field_char(b);
        end
        run_sum = run_sum + b;
        if (parsed_pos < FIELD_START + 1)
        begin
            parsed_pos++;
        end
    endtask

    function automatic int tail_digit(input logic [7:0] c);
        if (c >= acfp_pkg::CH_ZERO && c <= acfp_pkg::CH_NINE)
        begin
            return int'(c - acfp_pkg::CH_ZERO);
        end
        if (c >= acfp_pkg::CH_UP_A && c <= acfp_pkg::CH_UP_F)
        begin
            return int'(c - acfp_pkg::CH_UP_A) + 10;
        end
        if (c >= acfp_pkg::CH_LO_A && c <= acfp_pkg::CH_LO_F)
        begin
            return int'(c - acfp_pkg::CH_LO_A) + 10;
        end
        return -1;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic last);
        acfp_pkg::frame_out_t res;
        bit                   ok;
        int                   hi;
        int                   lo;
        if (tail_cnt == 3)
        begin
            parsed_char(tail_hold[0]);
        end
        tail_hold[0] = tail_hold[1];
        tail_hold[1] = tail_hold[2];
        tail_hold[2] = b;
        if (tail_cnt < 3)
        begin
            tail_cnt++;
        end
        if (!last)
        begin
            return;
        end
        if (!frame_bad && fld_num < 4 && fld_seen)
        begin
            close_field();
        end
        ok = tail_cnt == 3 && parsed_pos > FIELD_START && lead_ok &&
             !frame_bad && fld_num >= 4;
        if (ok && chk_on)
        begin
            hi = tail_digit(tail_hold[1]);
            lo = tail_digit(tail_hold[2]);
            if (hi < 0 || lo < 0 || (hi * 16 + lo) != int'(run_sum))
            begin
                ok = 1'b0;
            end
        end
        res.frame_valid            = ok;
        res.static_pressure_count  = ok ? fld_vals[0] : '0;
        res.dynamic_pressure_count = ok ? fld_vals[1] : '0;
        res.alpha_count            = ok ? fld_vals[2] : '0;
        res.beta_count             = ok ? fld_vals[3] : '0;
        frame_results_q.push_back(use_typed ? typed_want : res);
        clear_frame_state();
    endtask

    // ------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------
    logic [7:0] frame_buf [$];

    function automatic acfp_pkg::frame_out_t want_counts(input bit v, input int a,
                                                         input int b, input int c,
                                                         input int d);
        acfp_pkg::frame_out_t r;
        r.frame_valid            = v;
        r.static_pressure_count  = a;
        r.dynamic_pressure_count = b;
        r.alpha_count            = c;
        r.beta_count             = d;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return acfp_pkg::CH_ZERO + 8'(n);
        end
        return (upper ? acfp_pkg::CH_UP_A : acfp_pkg::CH_LO_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_tail(input tail_kind_t kind, input string txt, input logic [7:0] sep);
        logic [7:0] s;
        s = '0;
        foreach (frame_buf[i])
        begin
            s = s + frame_buf[i];
        end
        if (kind == TAIL_WRONG)
        begin
            s = s + 8'd1;
        end
        if (kind == TAIL_TEXT)
        begin
            for (int i = 0; i < txt.len(); i++)
            begin
                frame_buf.push_back(txt[i]);
            end
        end
        else
        begin
            frame_buf.push_back(sep);
            frame_buf.push_back(hex_char(s[7:4], kind != TAIL_LOWER));
            frame_buf.push_back(hex_char(s[3:0], kind != TAIL_LOWER));
        end
    endtask

    task automatic add_random_field();
        int         r;
        int         n;
        logic [7:0] b;
        if ($urandom_range(0, 99) < 3)
        begin
            return;
        end
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            frame_buf.push_back($urandom_range(0, 1) ? acfp_pkg::CH_SPACE : acfp_pkg::CH_TAB);
        end
        r = $urandom_range(0, 2);
        if (r == 1)
        begin
            frame_buf.push_back(acfp_pkg::CH_PLUS);
        end
        else if (r == 2)
        begin
            frame_buf.push_back(acfp_pkg::CH_MINUS);
        end
        r = $urandom_range(0, 99);
        n = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(9, 12);
        repeat (n)
        begin
            frame_buf.push_back(acfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        // junk after the digits: random bytes other than a comma
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                do
                begin
                    b = rand_byte();
                end
                while (b == acfp_pkg::CH_COMMA);
                frame_buf.push_back(b);
            end
        end
    endtask

    task automatic build_random_frame();
        int         r;
        int         n;
        int         nf;
        logic [7:0] sep;
        frame_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            n = $urandom_range(1, 45);
            repeat (n)
            begin
                frame_buf.push_back(rand_byte());
            end
            return;
        end
        frame_buf.push_back(($urandom_range(0, 19) == 0) ? rand_byte() : acfp_pkg::CH_DOLLAR);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 25) : FIELD_START - 1;
        repeat (n)
        begin
            frame_buf.push_back(rand_byte());
        end
        nf = (r < 80) ? 4 : $urandom_range(1, 6);
        for (int i = 0; i < nf; i++)
        begin
            if (i > 0)
            begin
                frame_buf.push_back(acfp_pkg::CH_COMMA);
            end
            add_random_field();
        end
        if ($urandom_range(0, 9) == 0)
        begin
            frame_buf.push_back(acfp_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 99) < 6)
        begin
            frame_buf[$urandom_range(0, frame_buf.size() - 1)] = rand_byte();
        end
        sep = ($urandom_range(0, 9) == 0) ? rand_byte() : CH_STAR;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            add_tail(TAIL_UPPER, "", sep);
        end
        else if (r < 80)
        begin
            add_tail(TAIL_LOWER, "", sep);
        end
        else if (r < 90)
        begin
            add_tail(TAIL_WRONG, "", sep);
        end
        else
        begin
            frame_buf.push_back(sep);
            frame_buf.push_back(rand_byte());
            frame_buf.push_back(rand_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------
    int items_sent    = 0;
    bit src_calm      = 1'b0;
    bit sink_calm     = 1'b0;
    bit sink_hold_req = 1'b0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_data.frame_byte <= b;
        in_data.frame_end  <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        predict_byte(b, last);
    endtask

    task automatic send_frame();
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // sender pauses until every frame result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (frame_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_cfg(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        chk_on = v;
    endtask

    // receiver side
    initial
    begin
        int stall;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                stall = SINK_HOLD_CYC;
            end
            else
            begin
                stall = sink_calm ? 0 : idle_len();
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    acfp_pkg::frame_out_t want_now;

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results_q.size() == 0)
            begin
                $display("%0t: result with none expected, expected none, actual valid=%0b",
                         $time, out_data.frame_valid);
                fail_count++;
            end
            else
            begin
                want_now = frame_results_q.pop_front();
                check_field("frame_valid", 32'(want_now.frame_valid),
                            32'(out_data.frame_valid));
                check_field("static_pressure_count", want_now.static_pressure_count,
                            out_data.static_pressure_count);
                check_field("dynamic_pressure_count", want_now.dynamic_pressure_count,
                            out_data.dynamic_pressure_count);
                check_field("alpha_count", want_now.alpha_count, out_data.alpha_count);
                check_field("beta_count", want_now.beta_count, out_data.beta_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    frame_row_t frame_rows [NUM_ROWS];

    initial
    begin
        int rand_base;
        int goal;
        frame_rows = '{
            '{"$ABCDEFGHIJKLMNOPQRST1,2,3,4", TAIL_UPPER, "", 1'b1, 1'b1,
              want_counts(1, 1, 2, 3, 4)},
            '{"$ABCDEFGHIJKLMNOPQRST2147483647,-2147483647,0,99999999999", TAIL_LOWER, "",
              1'b1, 1'b1, want_counts(1, 2147483647, -2147483647, 0, 2147483647)},
            '{"$ABCDEFGHIJKLMNOPQRST \t+12x9,- 5,  -7abc,+", TAIL_UPPER, "", 1'b1, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST1,,3,4", TAIL_UPPER, "", 1'b1, 1'b1,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST1,2,3,4,", TAIL_UPPER, "", 1'b1, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST1,2,3,", TAIL_UPPER, "", 1'b1, 1'b1,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST10,20,30,40,50,,x", TAIL_UPPER, "", 1'b1, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"#ABCDEFGHIJKLMNOPQRST1,2,3,4", TAIL_UPPER, "", 1'b1, 1'b1,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABC,1,2,3,4", TAIL_UPPER, "", 1'b1, 1'b1, want_counts(0, 0, 0, 0, 0)},
            '{"", TAIL_TEXT, "*5", 1'b1, 1'b1, want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST5,6,7,8", TAIL_TEXT, "*G0", 1'b1, 1'b1,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST5,6,7,8", TAIL_WRONG, "", 1'b1, 1'b1,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST5,6,7,8", TAIL_TEXT, "*G0", 1'b0, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST5,6,7,8", TAIL_WRONG, "", 1'b0, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST-0,+0,00012,-000", TAIL_UPPER, "", 1'b0, 1'b0,
              want_counts(0, 0, 0, 0, 0)},
            '{"$ABCDEFGHIJKLMNOPQRST\t-99,\t 3 4,7,,", TAIL_LOWER, "", 1'b1, 1'b0,
              want_counts(0, 0, 0, 0, 0)}
        };

        clear_frame_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_cfg(1'b1);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (frame_rows[i].chk != chk_on)
            begin
                settle();
                write_cfg(frame_rows[i].chk);
            end
            frame_buf.delete();
            for (int k = 0; k < frame_rows[i].body.len(); k++)
            begin
                frame_buf.push_back(frame_rows[i].body[k]);
            end
            add_tail(frame_rows[i].tail, frame_rows[i].tail_txt, CH_STAR);
            use_typed  = frame_rows[i].typed;
            typed_want = frame_rows[i].want;
            send_frame();
            use_typed = 1'b0;
        end

        // random frames in four phases, checksum off and on in turn; the receiver
        // holds off for a long stretch at the start of the second one
        rand_base = items_sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            write_cfg(ph % 2 == 1);
            if (ph == 1)
            begin
                sink_hold_req = 1'b1;
            end
            goal = rand_base + (ph + 1) * (ITEM_GOAL - rand_base) / 4;
            while (items_sent < goal)
            begin
                build_random_frame();
                send_frame();
                if ($urandom_range(0, 24) == 0)
                begin
                    settle();
                end
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && frame_results_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/acfp_pkg.sv
sv/acfp_fields.sv
sv/ascii_count_frame_parser_core.sv
bench/tb.sv
